/* rtl/fdwt_pkg.sv */
// ----------------------------------------------------------------------------
// fdwt_pkg
// Shared types and constants for the frame difference window block.
// ----------------------------------------------------------------------------
package fdwt_pkg;

  localparam int MaxPixels  = 65536;
  localparam int AddrW      = $clog2(MaxPixels);
  localparam int TableDepth = 256;
  localparam int TidxW      = $clog2(TableDepth);

  localparam logic [1:0] CMD_LOAD_CUR  = 2'd0;
  localparam logic [1:0] CMD_LOAD_PREV = 2'd1;
  localparam logic [1:0] CMD_PIXEL     = 2'd2;
  localparam logic [1:0] CMD_READ      = 2'd3;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PAL    = 3'd2;
  localparam logic [2:0] REG_DIFF   = 3'd3;
  localparam logic [2:0] REG_TRANS  = 3'd4;
  localparam logic [2:0] REG_USER   = 3'd5;
  localparam logic [2:0] REG_FIRST  = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  color_index;
    logic [23:0] color_rgb;
    logic [7:0]  cur_pixel;
    logic [7:0]  prev_pixel;
    logic        last_pixel;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] win_left;
    logic [11:0] win_top;
    logic [12:0] win_width;
    logic [12:0] win_height;
    logic [7:0]  trans_index;
    logic        trans_flag;
    logic [7:0]  pixel_value;
    logic        window_last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // register the incoming item, issue table writes/reads
    logic load;      // perform the pixel / read update with read data
    logic mul;       // register address product
    logic finish;    // write store / read store entry for the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_result;
  } status_t;

  function automatic logic [12:0] clamp13(input logic [12:0] v);
    if (v == 13'd0) return 13'd1;
    if (v > 13'd4096) return 13'd4096;
    return v;
  endfunction

endpackage

/* rtl/frame_diff_window_transparency.sv */
// Each accepted transaction passes through the read, update, multiply and
// finish steps before a result is offered; a new transaction is accepted only
// once the last one is through and its result, if any, has been taken. This is
// set by the multi-step sequencer around the single pixel store port and the address multiplier.
// Reset: synchronous, active high; clears configuration, controller state, positions and box.
// Color tables and pixel store hold undefined data until written.
// ----------------------------------------------------------------------------
// frame_diff_window_transparency
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
module frame_diff_window_transparency (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // command, color_index, color_rgb, cur_pixel, prev_pixel
  input  logic        s_axis_tlast,  // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // win_left, win_top, win_width, win_height,
                                     // trans_index, trans_flag, pixel_value
  output logic        m_axis_tuser,  // kind
  output logic        m_axis_tlast,  // window_last
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  fdwt_pkg::cmd_t    cmd;
  fdwt_pkg::status_t status;
  fdwt_pkg::item_t   item;
  fdwt_pkg::result_t res;
  logic in_fire, out_fire;
  logic [5:0] tdata_pad_unused;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;

  assign item.command     = s_axis_tdata[1:0];
  assign item.color_index = s_axis_tdata[9:2];
  assign item.color_rgb   = s_axis_tdata[33:10];
  assign item.cur_pixel   = s_axis_tdata[41:34];
  assign item.prev_pixel  = s_axis_tdata[49:42];
  assign item.last_pixel  = s_axis_tlast;
  assign tdata_pad_unused = s_axis_tdata[55:50];

  fdwt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .status(status), .out_fire(out_fire),
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .cmd(cmd)
  );

  fdwt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .item(item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .status(status), .result(res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.window_last;
  assign m_axis_tdata = {5'd0, res.pixel_value, res.trans_flag, res.trans_index,
                         res.win_height, res.win_width, res.win_top, res.win_left};

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_desc_kind: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> !m_axis_tlast) else $error("descriptor with last");
  a_win_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[36:24] != 13'd0 && m_axis_tdata[49:37] != 13'd0))
    else $error("empty window");
`endif

endmodule

/* rtl/fdwt_ctrl.sv */
// ----------------------------------------------------------------------------
// fdwt_ctrl
// Controller: sequences one transaction through read, update, address and
// commit steps and holds the result until taken.
// ----------------------------------------------------------------------------
module fdwt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  fdwt_pkg::status_t   status,
  input  logic                out_fire,
  output logic                in_ready,
  output logic                out_valid,
  output fdwt_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_UPD  = 6'b000100,
    S_MUL  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.capture = in_fire;
        if (in_fire) state_next = S_RD;
      end
      S_RD: begin
        cmd.load = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.mul = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.finish = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = status.has_result ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (out_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

/* rtl/fdwt_dp.sv */
// ----------------------------------------------------------------------------
// fdwt_dp
// Datapath: color tables, pixel store, load and read positions, bounding box
// and window descriptor.
// ----------------------------------------------------------------------------
module fdwt_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  fdwt_pkg::cmd_t       cmd,
  input  fdwt_pkg::item_t      item,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [12:0]          cfg_data,
  output fdwt_pkg::status_t    status,
  output fdwt_pkg::result_t    result
);

  logic [12:0] frame_width, frame_height;
  logic [8:0]  palette_entries;
  logic diff_window_enable, transparency_enable, user_transparency, first_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 13'd1;
      frame_height <= 13'd1;
      palette_entries <= 9'd256;
      diff_window_enable <= 1'b0;
      transparency_enable <= 1'b0;
      user_transparency <= 1'b0;
      first_frame <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        fdwt_pkg::REG_WIDTH:  frame_width <= cfg_data;
        fdwt_pkg::REG_HEIGHT: frame_height <= cfg_data;
        fdwt_pkg::REG_PAL:    palette_entries <= cfg_data[8:0];
        fdwt_pkg::REG_DIFF:   diff_window_enable <= cfg_data[0];
        fdwt_pkg::REG_TRANS:  transparency_enable <= cfg_data[0];
        fdwt_pkg::REG_USER:   user_transparency <= cfg_data[0];
        fdwt_pkg::REG_FIRST:  first_frame <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [12:0] wd, ht;
  assign wd = fdwt_pkg::clamp13(frame_width);
  assign ht = fdwt_pkg::clamp13(frame_height);

  // window
  logic [8:0] n;
  logic off, diff_on, trans_on;
  logic [7:0] tval;
  logic [11:0] box_min_row, box_max_row, box_min_col, box_max_col;
  logic any_difference;
  logic [11:0] w_left, w_top;
  logic [12:0] w_w, w_h;

  always_comb begin
    if (palette_entries == 9'd0) n = 9'd1;
    else if (palette_entries > 9'd256) n = 9'd256;
    else n = palette_entries;
    off = first_frame | user_transparency;
    diff_on = diff_window_enable & ~off;
    trans_on = transparency_enable & ~off & (n != 9'd256);
    if (n <= 9'd3) tval = 8'd7;
    else if (n <= 9'd7) tval = 8'd7;
    else if (n <= 9'd15) tval = 8'd15;
    else if (n <= 9'd31) tval = 8'd31;
    else if (n <= 9'd63) tval = 8'd63;
    else if (n <= 9'd127) tval = 8'd127;
    else tval = 8'd255;
    if (n == 9'd4) tval = 8'd7;
    if (n <= 9'd3) tval = 8'd3;
    if (!diff_on) begin
      w_left = '0; w_top = '0; w_w = wd; w_h = ht;
    end else if (!any_difference || box_max_col < box_min_col ||
                 box_max_row < box_min_row) begin
      w_left = '0; w_top = '0; w_w = 13'd1; w_h = 13'd1;
    end else begin
      w_left = box_min_col; w_top = box_min_row;
      w_w = {1'b0, box_max_col} - {1'b0, box_min_col} + 13'd1;
      w_h = {1'b0, box_max_row} - {1'b0, box_min_row} + 13'd1;
    end
  end

  // tables
  logic [23:0] cur_tab [fdwt_pkg::TableDepth];
  logic [23:0] prev_tab [fdwt_pkg::TableDepth];
  logic [23:0] cur_rgb, prev_rgb;
  fdwt_pkg::item_t it;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it <= item;
      if (item.command == fdwt_pkg::CMD_LOAD_CUR)
        cur_tab[item.color_index[fdwt_pkg::TidxW-1:0]] <= item.color_rgb;
      if (item.command == fdwt_pkg::CMD_LOAD_PREV)
        prev_tab[item.color_index[fdwt_pkg::TidxW-1:0]] <= item.color_rgb;
      cur_rgb <= cur_tab[item.cur_pixel[fdwt_pkg::TidxW-1:0]];
      prev_rgb <= prev_tab[item.prev_pixel[fdwt_pkg::TidxW-1:0]];
    end
  end

  // positions
  logic [12:0] load_col, load_row;
  logic [11:0] read_col, read_row;
  logic [11:0] rc_eff, rr_eff;
  logic [12:0] row_sel, col_sel;
  logic differs, do_store;
  logic [8:0] st_data;
  logic [25:0] prod;
  logic [26:0] addr_full;
  logic res_last;

  assign differs = (cur_rgb != prev_rgb);
  assign rc_eff = ({1'b0, read_col} >= w_w || {1'b0, read_row} >= w_h) ? 12'd0 : read_col;
  assign rr_eff = ({1'b0, read_col} >= w_w || {1'b0, read_row} >= w_h) ? 12'd0 : read_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_col <= '0; load_row <= '0;
      read_col <= '0; read_row <= '0;
      box_min_row <= '1; box_max_row <= '0;
      box_min_col <= '1; box_max_col <= '0;
      any_difference <= 1'b0;
      do_store <= 1'b0;
    end else begin
      if (cmd.capture) do_store <= 1'b0;
      if (cmd.load && it.command == fdwt_pkg::CMD_PIXEL) begin
        row_sel <= load_row;
        col_sel <= load_col;
        st_data <= {differs, it.cur_pixel};
        if (load_row < ht && load_col < wd) begin
          do_store <= 1'b1;
          if (load_col + 13'd1 >= wd) begin
            load_col <= '0; load_row <= load_row + 13'd1;
          end else load_col <= load_col + 13'd1;
        end else if (load_row < ht) begin
          load_col <= '0; load_row <= load_row + 13'd1;
        end else begin
          load_col <= '0; load_row <= ht;
        end
        if (load_row == '0 && load_col == '0) begin
          any_difference <= differs;
          box_min_row <= differs ? 12'd0 : 12'hFFF;
          box_max_row <= 12'd0;
          box_min_col <= differs ? 12'd0 : 12'hFFF;
          box_max_col <= 12'd0;
        end else if (differs && load_row < ht && load_col < wd) begin
          any_difference <= 1'b1;
          if (load_row[11:0] < box_min_row) box_min_row <= load_row[11:0];
          if (load_row[11:0] > box_max_row) box_max_row <= load_row[11:0];
          if (load_col[11:0] < box_min_col) box_min_col <= load_col[11:0];
          if (load_col[11:0] > box_max_col) box_max_col <= load_col[11:0];
        end
      end
      if (cmd.load && it.command == fdwt_pkg::CMD_READ) begin
        row_sel <= {1'b0, w_top} + {1'b0, rr_eff};
        col_sel <= {1'b0, w_left} + {1'b0, rc_eff};
        res_last <= ({1'b0, rc_eff} == w_w - 13'd1) && ({1'b0, rr_eff} == w_h - 13'd1);
        if ({1'b0, rc_eff} + 13'd1 >= w_w) begin
          read_col <= '0;
          read_row <= ({1'b0, rr_eff} + 13'd1 >= w_h) ? 12'd0 : rr_eff + 12'd1;
        end else begin
          read_col <= rc_eff + 12'd1; read_row <= rr_eff;
        end
      end
      if (cmd.load && it.command == fdwt_pkg::CMD_PIXEL && it.last_pixel) begin
        load_col <= '0; load_row <= '0;
        read_col <= '0; read_row <= '0;
      end
    end
  end

  // address multiply and store
  logic [8:0] store [fdwt_pkg::MaxPixels];
  logic [8:0] rd_entry;
  logic in_range;

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= 26'(row_sel) * 26'(wd);
  end
  assign addr_full = {1'b0, prod} + {14'd0, col_sel};
  assign in_range = addr_full < 27'(fdwt_pkg::MaxPixels);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (it.command == fdwt_pkg::CMD_PIXEL && do_store && in_range)
        store[addr_full[fdwt_pkg::AddrW-1:0]] <= st_data;
      rd_entry <= in_range ? store[addr_full[fdwt_pkg::AddrW-1:0]] : 9'd0;
    end
  end

  logic is_read;
  assign is_read = (it.command == fdwt_pkg::CMD_READ);
  assign status.has_result = is_read ||
                             (it.command == fdwt_pkg::CMD_PIXEL && it.last_pixel);

  always_comb begin
    result = '0;
    result.kind = is_read;
    result.win_left = w_left;
    result.win_top = w_top;
    result.win_width = w_w;
    result.win_height = w_h;
    result.trans_index = trans_on ? tval : 8'd0;
    result.trans_flag = user_transparency | trans_on;
    if (is_read) begin
      result.pixel_value = (trans_on && !rd_entry[8]) ? tval : rd_entry[7:0];
      result.window_last = res_last;
    end
  end

endmodule
